/* sv/dsfc_pkg.sv */
`default_nettype none

package dsfc_pkg;

  // Field widths
  localparam int unsigned SampleW = 16;
  localparam int unsigned CodeW   = 8;
  localparam int unsigned PctW    = 7;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 7;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_FORCE_FAN = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ON_LEVEL  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_OFF_LEVEL = 2'd2;

  // Configuration reset values
  localparam logic [PctW-1:0] ON_LEVEL_RST  = 7'd50;
  localparam logic [PctW-1:0] OFF_LEVEL_RST = 7'd30;

  // Staircase table: code threshold and percent level of each step
  localparam int unsigned StairCount = 22;
  localparam logic [CodeW-1:0] STAIR_CODE [StairCount] = '{
    8'd71,  8'd78,  8'd85,  8'd92,  8'd100, 8'd107, 8'd114, 8'd121,
    8'd127, 8'd134, 8'd140, 8'd146, 8'd151, 8'd156, 8'd161, 8'd166,
    8'd170, 8'd174, 8'd178, 8'd181, 8'd184, 8'd187
  };
  localparam logic [PctW-1:0] STAIR_PCT [StairCount] = '{
    7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd6,  7'd12, 7'd18,
    7'd24, 7'd30, 7'd36, 7'd42, 7'd48, 7'd54, 7'd60, 7'd66,
    7'd72, 7'd78, 7'd84, 7'd90, 7'd96, 7'd100
  };

  // Sequencer phases
  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_STATOR = 2'd1,
    PH_BULB   = 2'd2,
    PH_EVAL   = 2'd3
  } phase_e;

endpackage

`default_nettype wire

/* sv/dsfc_pct.sv */
`default_nettype none

module dsfc_pct (
  input  wire logic [dsfc_pkg::SampleW-1:0] sample_i,
  output logic      [dsfc_pkg::PctW-1:0]    pct_o
);
  import dsfc_pkg::*;

  logic [CodeW-1:0] code;

  assign code = sample_i[SampleW-1 -: CodeW];

  // Pick the highest step whose threshold the code reaches; below the first is zero
  always_comb begin
    pct_o = '0;
    for (int k = 0; k < StairCount; k++) begin
      if (code >= STAIR_CODE[k]) begin
        pct_o = STAIR_PCT[k];
      end
    end
  end

endmodule

`default_nettype wire

/* sv/dual_sensor_temp_fan_control.sv */
`default_nettype none

// Channel  Direction  Handshake              Payload
// cfg      in         cfg_we_i               cfg_idx_i, cfg_data_i
// in       in         in_valid_i/in_stall_o  adc_sample_i
// out      out        out_valid_o/out_stall_i channel_select_o, fan_drive_o,
//                                            bulb_level_o, stator_level_o, report_valid_o
//
// Every input beat yields one output beat, registered and valid in the cycle after it is accepted.
// A beat can be accepted every cycle; the result register is the only stage.
// Input stalls only while a result waits and the output side stalls.
// Reset puts the sequencer at its start phase, levels at zero, fan off.

module dual_sensor_temp_fan_control (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [dsfc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [dsfc_pkg::CfgW-1:0]       cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [dsfc_pkg::SampleW-1:0]    adc_sample_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic                                 channel_select_o,
  output logic                                 fan_drive_o,
  output logic      [dsfc_pkg::PctW-1:0]       bulb_level_o,
  output logic      [dsfc_pkg::PctW-1:0]       stator_level_o,
  output logic                                 report_valid_o
);
  import dsfc_pkg::*;

  logic            force_fan_q;
  logic [PctW-1:0] on_level_q;
  logic [PctW-1:0] off_level_q;

  phase_e          phase_q, phase_d;
  logic [PctW-1:0] bulb_q, bulb_d;
  logic [PctW-1:0] stator_q, stator_d;
  logic            fan_q, fan_d;
  logic            chan_d;
  logic            report_d;

  logic            out_valid_q;
  logic            chan_q;
  logic            report_q;
  logic [PctW-1:0] bulb_out_q;
  logic [PctW-1:0] stator_out_q;
  logic            fan_out_q;

  logic            in_take;
  logic [PctW-1:0] sample_pct;

  // Accept while the result register is empty or being drained
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_take    = in_valid_i & ~in_stall_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      force_fan_q <= 1'b0;
      on_level_q  <= ON_LEVEL_RST;
      off_level_q <= OFF_LEVEL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FORCE_FAN: force_fan_q <= cfg_data_i[0];
        CFG_ON_LEVEL:  on_level_q  <= cfg_data_i;
        CFG_OFF_LEVEL: off_level_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dsfc_pct u_pct (
    .sample_i (adc_sample_i),
    .pct_o    (sample_pct)
  );

  // Sequencer next state and result
  always_comb begin
    phase_d  = phase_q;
    bulb_d   = bulb_q;
    stator_d = stator_q;
    fan_d    = fan_q;
    chan_d   = 1'b0;
    report_d = 1'b0;
    unique case (phase_q)
      PH_START: begin
        phase_d = PH_STATOR;
      end
      PH_STATOR: begin
        stator_d = sample_pct;
        chan_d   = 1'b1;
        phase_d  = PH_BULB;
      end
      PH_BULB: begin
        bulb_d  = sample_pct;
        phase_d = PH_EVAL;
      end
      PH_EVAL: begin
        report_d = 1'b1;
        phase_d  = PH_STATOR;
        priority if (force_fan_q) begin
          fan_d = 1'b1;
        end else if (bulb_q > on_level_q || stator_q > on_level_q) begin
          fan_d = 1'b1;
        end else if (bulb_q < off_level_q && stator_q < off_level_q) begin
          fan_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Advance sequencer state on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_START;
      bulb_q   <= '0;
      stator_q <= '0;
      fan_q    <= 1'b0;
    end else if (in_take) begin
      phase_q  <= phase_d;
      bulb_q   <= bulb_d;
      stator_q <= stator_d;
      fan_q    <= fan_d;
    end
  end

  // Result valid: set on accept, drop when drained
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload, held while stalled
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      chan_q       <= chan_d;
      report_q     <= report_d;
      bulb_out_q   <= bulb_d;
      stator_out_q <= stator_d;
      fan_out_q    <= fan_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign channel_select_o = chan_q;
  assign fan_drive_o      = fan_out_q;
  assign bulb_level_o     = bulb_out_q;
  assign stator_level_o   = stator_out_q;
  assign report_valid_o   = report_q;

endmodule

`default_nettype wire

/* test/fan_report_checker.sv */
`timescale 1ns / 1ps

module fan_report_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [dsfc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [dsfc_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [dsfc_pkg::SampleW-1:0] adc_sample_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic                        channel_select_i,
  input  logic                        fan_drive_i,
  input  logic [dsfc_pkg::PctW-1:0]    bulb_level_i,
  input  logic [dsfc_pkg::PctW-1:0]    stator_level_i,
  input  logic                        report_valid_i,
  output int                          err_count_o,
  output int                          pending_o
);
  import dsfc_pkg::*;

  localparam logic [PctW-1:0] FullPct = 7'd100;

  typedef struct packed {
    logic            chan;
    logic            fan;
    logic [PctW-1:0] bulb;
    logic [PctW-1:0] stator;
    logic            report;
  } fan_report_t;

  // Shadow of the sequencer and the threshold registers
  phase_e          seq_phase;
  logic            chan_next;
  logic            fan_on;
  logic [PctW-1:0] bulb_pct;
  logic [PctW-1:0] stator_pct;
  logic            force_fan;
  logic [PctW-1:0] on_level;
  logic [PctW-1:0] off_level;

  fan_report_t expected_reports[$];

  // Map the upper byte of a conversion onto the percent staircase
  function automatic logic [PctW-1:0] level_of_sample(input logic [SampleW-1:0] sample);
    logic [CodeW-1:0] code;
    logic [PctW-1:0]  pct;
    code = sample[SampleW-1 -: CodeW];
    pct  = STAIR_PCT[0];
    if (code <= STAIR_CODE[0]) return '0;
    if (code >= STAIR_CODE[StairCount-1]) return FullPct;
    for (int k = 1; k < StairCount; k++) begin
      if (code >= STAIR_CODE[k]) pct = STAIR_PCT[k];
    end
    return pct;
  endfunction

  function automatic int field_bad(input string name, input int exp_v, input int act_v);
    if (exp_v == act_v) return 0;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    fan_report_t exp_r;
    fan_report_t got_r;
    int          bad;
    if (!rst_ni) begin
      seq_phase   = PH_START;
      chan_next   = 1'b0;
      fan_on      = 1'b0;
      bulb_pct    = '0;
      stator_pct  = '0;
      force_fan   = 1'b0;
      on_level    = ON_LEVEL_RST;
      off_level   = OFF_LEVEL_RST;
      expected_reports.delete();
      err_count_o <= 0;
      pending_o   <= 0;
    end else begin
      // Track register writes; unknown indexes drop out
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FORCE_FAN: force_fan = cfg_data_i[0];
          CFG_ON_LEVEL:  on_level  = cfg_data_i[PctW-1:0];
          CFG_OFF_LEVEL: off_level = cfg_data_i[PctW-1:0];
          default: ;
        endcase
      end

      // Advance the sequencer on each accepted sample beat
      if (in_valid_i && !in_stall_i) begin
        exp_r.report = 1'b0;
        case (seq_phase)
          PH_START: begin
            chan_next = 1'b0;
            seq_phase = PH_STATOR;
          end
          PH_STATOR: begin
            stator_pct = level_of_sample(adc_sample_i);
            chan_next  = 1'b1;
            seq_phase  = PH_BULB;
          end
          PH_BULB: begin
            bulb_pct  = level_of_sample(adc_sample_i);
            chan_next = 1'b0;
            seq_phase = PH_EVAL;
          end
          default: begin
            exp_r.report = 1'b1;
            // Turn on when forced or above the on level, off only with both below the off level
            if (force_fan) fan_on = 1'b1;
            else if (bulb_pct > on_level || stator_pct > on_level) fan_on = 1'b1;
            else if (bulb_pct < off_level && stator_pct < off_level) fan_on = 1'b0;
            seq_phase = PH_STATOR;
          end
        endcase
        exp_r.chan   = chan_next;
        exp_r.fan    = fan_on;
        exp_r.bulb   = bulb_pct;
        exp_r.stator = stator_pct;
        expected_reports.push_back(exp_r);
      end

      // Compare each accepted report beat with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        got_r = '{channel_select_i, fan_drive_i, bulb_level_i, stator_level_i, report_valid_i};
        if (expected_reports.size() == 0) begin
          $display("%0t: report beat with nothing expected, actual %h", $time, got_r);
          err_count_o <= err_count_o + 1;
        end else begin
          exp_r = expected_reports.pop_front();
          bad = field_bad("channel_select", exp_r.chan, got_r.chan)
              + field_bad("fan_drive", exp_r.fan, got_r.fan)
              + field_bad("bulb_level", exp_r.bulb, got_r.bulb)
              + field_bad("stator_level", exp_r.stator, got_r.stator)
              + field_bad("report_valid", exp_r.report, got_r.report);
          err_count_o <= err_count_o + bad;
        end
      end

      pending_o <= expected_reports.size();
    end
  end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import dsfc_pkg::*;

  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;

  // Staircase edges, clamps and both extremes of the sample word
  localparam logic [SampleW-1:0] EDGE_SAMPLES [22] = '{
    16'hFFFF,
    16'h0000, 16'hFFFF, 16'h1234,
    16'h47FF, 16'h4800, 16'hEDCB,
    16'h4E00, 16'h6B00, 16'h0000,
    16'h6AFF, 16'hBA00, 16'hFFFF,
    16'hBB00, 16'hBC00, 16'h5555,
    16'h8600, 16'h85FF, 16'hAAAA,
    16'h7F00, 16'h0000, 16'h00FF
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = CFG_FORCE_FAN;
  logic [CfgW-1:0]    cfg_data = '0;
  logic               in_valid = 1'b0;
  logic [SampleW-1:0] adc_sample = '0;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic               channel_select;
  logic               fan_drive;
  logic [PctW-1:0]    bulb_level;
  logic [PctW-1:0]    stator_level;
  logic               report_valid;

  int report_errors;
  int reports_due;
  int send_idle_pct = 13;
  int recv_stall_pct = 53;

  dual_sensor_temp_fan_control dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .adc_sample_i     (adc_sample),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .channel_select_o (channel_select),
    .fan_drive_o      (fan_drive),
    .bulb_level_o     (bulb_level),
    .stator_level_o   (stator_level),
    .report_valid_o   (report_valid)
  );

  fan_report_checker checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .adc_sample_i     (adc_sample),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .channel_select_i (channel_select),
    .fan_drive_i      (fan_drive),
    .bulb_level_i     (bulb_level),
    .stator_level_i   (stator_level),
    .report_valid_i   (report_valid),
    .err_count_o      (report_errors),
    .pending_o        (reports_due)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Random back-pressure on the report side
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Hold a sample beat until it is taken, with random gaps ahead of it
  task automatic push_sample(input logic [SampleW-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    adc_sample <= value;
    do @(posedge clk); while (in_stall);
  endtask

  // Wait until every predicted report has come out
  task automatic drain_reports();
    in_valid <= 1'b0;
    do @(posedge clk); while (reports_due != 0);
    repeat (3) @(posedge clk);
  endtask

  // Write all registers, plus one write to an unused index that must drop out
  task automatic program_regs(input logic force_on, input logic [PctW-1:0] on_lvl,
                              input logic [PctW-1:0] off_lvl);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_FORCE_FAN;
    cfg_data <= {6'($urandom), force_on};
    @(posedge clk);
    cfg_idx  <= CFG_ON_LEVEL;
    cfg_data <= on_lvl;
    @(posedge clk);
    cfg_idx  <= CFG_OFF_LEVEL;
    cfg_data <= off_lvl;
    @(posedge clk);
    cfg_idx  <= CFG_UNUSED;
    cfg_data <= 7'($urandom);
    @(posedge clk);
    cfg_we   <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly codes around the staircase, some anywhere in the word
  function automatic logic [SampleW-1:0] rand_sample();
    logic [CodeW-1:0] code;
    if ($urandom_range(9) < 7) code = 8'($urandom_range(200, 60));
    else code = 8'($urandom);
    return {code, 8'($urandom)};
  endfunction

  // Levels that land on the staircase now and then, to hit the compare edges
  function automatic logic [PctW-1:0] rand_level();
    if ($urandom_range(1) == 0) return STAIR_PCT[$urandom_range(StairCount-1)];
    return 7'($urandom);
  endfunction

  initial begin
    int blk;
    int n;
    logic            force_on;
    logic [PctW-1:0] on_lvl;
    logic [PctW-1:0] off_lvl;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (EDGE_SAMPLES[i]) push_sample(EDGE_SAMPLES[i]);
    drain_reports();

    for (blk = 0; blk < 12; blk++) begin
      if (blk == 4) begin
        send_idle_pct  = 53;
        recv_stall_pct = 13;
      end
      if (blk == 8) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      force_on = 1'b0;
      case (blk % 6)
        0: begin
          on_lvl  = ON_LEVEL_RST;
          off_lvl = OFF_LEVEL_RST;
        end
        1: begin
          force_on = 1'b1;
          on_lvl   = rand_level();
          off_lvl  = rand_level();
        end
        2: begin
          on_lvl  = 7'd0;
          off_lvl = 7'd127;
        end
        3: begin
          on_lvl  = 7'd100;
          off_lvl = 7'd100;
        end
        4: begin
          on_lvl  = 7'd127;
          off_lvl = 7'd0;
        end
        default: begin
          on_lvl  = rand_level();
          off_lvl = rand_level();
        end
      endcase
      program_regs(force_on, on_lvl, off_lvl);
      for (n = 0; n < 54; n++) push_sample(rand_sample());
      drain_reports();
    end

    if (report_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Bound the run well beyond the slowest legal schedule
  initial begin
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
